// ===== sv/ctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

  localparam int SWITCH_BITS = 10;

  localparam int HUND_W = 7;
  localparam int SIXTY_W = 6;

  localparam logic [HUND_W-1:0]  MAX_HUND  = HUND_W'(99);
  localparam logic [SIXTY_W-1:0] MAX_SIXTY = SIXTY_W'(59);

  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_TOGGLE   = 3'd1;
  localparam logic [2:0] MODE_SET_HUND = 3'd2;
  localparam logic [2:0] MODE_SET_SEC  = 3'd3;
  localparam logic [2:0] MODE_SET_MIN  = 3'd4;

  localparam logic [7:0] SEG_ZERO = 8'h3F;

  typedef struct packed {
    logic [2:0]             mode;
    logic [SWITCH_BITS-1:0] switch_value;
  } ctd_in_t;

  typedef struct packed {
    logic [31:0] seg_low_digits;
    logic [15:0] seg_high_digits;
    logic        is_running;
    logic        expired;
  } ctd_out_t;

  // segment pattern, bit 0 = segment a
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = SEG_ZERO;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7C;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = SEG_ZERO;
    endcase
    return s;
  endfunction

  // two segment bytes (tens, ones) of a value below 100; v/10 = (v*205)>>11
  function automatic logic [15:0] seg_pair(input logic [HUND_W-1:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    p        = 15'(v) * 15'd205;
    tens     = p[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    ones     = 4'(v - tens_x10);
    return {seg_of(tens), seg_of(ones)};
  endfunction

endpackage

`default_nettype wire

// ===== sv/countdown_timer_seven_segment_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload     Handshake
// in_      input      ctd_in_t    in_valid / in_ready
// out_     output     ctd_out_t   out_valid / out_ready
//
// The counter update and the segment decode sit between the state registers
// and the result register, so a transfer can be taken every cycle while
// out_ready is high.
// Reset loads 59:59.59 with the countdown running and empties the result
// register. A stalled result blocks input only while out_ready is low.

module countdown_timer_seven_segment_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ctd_pkg::ctd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctd_pkg::ctd_out_t      out_data
);

  import ctd_pkg::*;

  logic [HUND_W-1:0]  hund_r, hund_nxt;
  logic [SIXTY_W-1:0] sec_r, sec_nxt;
  logic [SIXTY_W-1:0] min_r, min_nxt;
  logic               running_r, running_nxt;
  logic               out_valid_r;
  ctd_out_t           out_data_r, out_data_nxt;
  logic               in_xfer;
  logic               at_zero;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign at_zero = (hund_r == '0) && (sec_r == '0) && (min_r == '0);

  always_comb begin
    hund_nxt    = hund_r;
    sec_nxt     = sec_r;
    min_nxt     = min_r;
    running_nxt = running_r;
    case (in_data.mode)
      MODE_TICK: begin
        if (running_r && !at_zero) begin
          if (hund_r != '0) begin
            hund_nxt = hund_r - 1'b1;
          end else begin
            hund_nxt = MAX_HUND;
            if (sec_r != '0) begin
              sec_nxt = sec_r - 1'b1;
            end else begin
              sec_nxt = MAX_SIXTY;
              min_nxt = min_r - 1'b1;
            end
          end
        end
      end
      MODE_TOGGLE: running_nxt = !running_r;
      MODE_SET_HUND: begin
        hund_nxt = (in_data.switch_value > SWITCH_BITS'(MAX_HUND)) ?
                   MAX_HUND : HUND_W'(in_data.switch_value);
      end
      MODE_SET_SEC: begin
        sec_nxt = (in_data.switch_value > SWITCH_BITS'(MAX_SIXTY)) ?
                  MAX_SIXTY : SIXTY_W'(in_data.switch_value);
      end
      MODE_SET_MIN: begin
        min_nxt = (in_data.switch_value > SWITCH_BITS'(MAX_SIXTY)) ?
                  MAX_SIXTY : SIXTY_W'(in_data.switch_value);
      end
      default: ;
    endcase

    out_data_nxt.seg_low_digits  = {seg_pair(HUND_W'(sec_nxt)), seg_pair(hund_nxt)};
    out_data_nxt.seg_high_digits = seg_pair(HUND_W'(min_nxt));
    out_data_nxt.is_running      = running_nxt;
    out_data_nxt.expired         = (hund_nxt == '0) && (sec_nxt == '0) && (min_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hund_r      <= HUND_W'(59);
      sec_r       <= MAX_SIXTY;
      min_r       <= MAX_SIXTY;
      running_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        hund_r      <= hund_nxt;
        sec_r       <= sec_nxt;
        min_r       <= min_nxt;
        running_r   <= running_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hund_r <= MAX_HUND) && (sec_r <= MAX_SIXTY) && (min_r <= MAX_SIXTY))
    else $error("timer counter out of range");

  a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_data.mode == MODE_TICK) && !running_r |=>
      $stable(hund_r) && $stable(sec_r) && $stable(min_r))
    else $error("tick changed counters while stopped");

  a_expired_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.expired |->
      (out_data_r.seg_low_digits == {4{SEG_ZERO}}) &&
      (out_data_r.seg_high_digits == {2{SEG_ZERO}}))
    else $error("expired result shows nonzero digits");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_running == running_r) &&
      (out_data_r.expired == at_zero))
    else $error("result flags disagree with timer state");
`endif

endmodule

`default_nettype wire
